// ===== rtl/rbcs_pkg.sv =====
`default_nettype none
package rbcs_pkg;

    localparam int ROWS_DEF  = 8;
    localparam int NODES_DEF = 32;

    localparam int MODE_W  = 2;
    localparam int ID_W    = 16;
    localparam int SRC_W   = 5;
    localparam int TIME_W  = 32;
    localparam int CFG_W   = 8;
    localparam int NOBS_W  = 6;
    localparam int USED_W  = 4;

    localparam logic [MODE_W-1:0] MODE_REMOTE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOCAL  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OTHER  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;

    typedef enum logic [4:0] {
        S_CLR,
        S_IDLE,
        S_P_LOC,
        S_P_LOCD,
        S_P_CNT,
        S_P_CNTD,
        S_P_CAND,
        S_P_CANDD,
        S_P_CMP,
        S_P_CMPD,
        S_P_ACC,
        S_P_RCLR,
        S_P_NEXT,
        S_DIV_START,
        S_DIV_WAIT,
        S_LOCAL,
        S_MOD_START,
        S_MOD_WAIT,
        S_PREP,
        S_PCLR,
        S_WRITE,
        S_OUT
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/rbcs_if.sv =====
`default_nettype none
interface rbcs_in_if import rbcs_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   broadcast_id;
    logic [SRC_W-1:0]  source_node;
    logic [TIME_W-1:0] time_value;
    logic              start_of_set;

    modport source (output valid, mode, broadcast_id, source_node, time_value, start_of_set,
                    input ready);
    modport sink (input valid, mode, broadcast_id, source_node, time_value, start_of_set,
                  output ready);
endinterface

interface rbcs_out_if import rbcs_pkg::*; ;
    logic                     valid;
    logic                     ready;
    logic                     adjusted;
    logic signed [TIME_W-1:0] average_offset;
    logic [NOBS_W-1:0]        nodes_observed;
    logic [USED_W-1:0]        references_used;
    logic [ID_W-1:0]          reply_id;
    logic [TIME_W-1:0]        reply_time;

    modport source (output valid, adjusted, average_offset, nodes_observed, references_used,
                    reply_id, reply_time, input ready);
    modport sink (input valid, adjusted, average_offset, nodes_observed, references_used,
                  reply_id, reply_time, output ready);
endinterface
`default_nettype wire

// ===== rtl/rbcs_store.sv =====
`default_nettype none
module rbcs_store import rbcs_pkg::*; #(
    parameter int AW = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_addr,
    input  wire logic [TIME_W-1:0] i_wdata,
    output logic      [TIME_W-1:0] o_rdata
);

    logic [TIME_W-1:0] r_mem [2**AW];
    logic [TIME_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/rbcs_div.sv =====
`default_nettype none
module rbcs_div import rbcs_pkg::*; #(
    parameter int W = 33
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [W-1:0] i_dividend,
    input  wire logic [W-1:0] i_divisor,
    output logic              o_done,
    output logic      [W-1:0] o_quot
);

    localparam int CNTW = $clog2(W + 1);

    logic [W-1:0]    r_q, r_r, r_d;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy, r_done;
    logic [W:0]      trial, diff;

    assign trial = {r_r, r_q[W-1]};
    assign diff  = trial - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(W);
                r_q    <= i_dividend;
                r_r    <= '0;
                r_d    <= i_divisor;
            end else if (r_busy) begin
                if (!diff[W]) begin
                    r_r <= diff[W-1:0];
                    r_q <= {r_q[W-2:0], 1'b1};
                end else begin
                    r_r <= trial[W-1:0];
                    r_q <= {r_q[W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule
`default_nettype wire

// ===== rtl/reference_broadcast_clock_sync.sv =====
// remote observation: row index, then a row clear sweep when the row holds another id
// local arrival without set start: offset added, then row index, row clear sweep and reply
// set processing: each row is scanned node by node, paced by the
// single store read port; then a divide of the offset sum by the rows used
// one request at a time; reset clears every store entry, ROWS' * 2^clog2(NODES) of
// them (256 by default, ROWS' the rows rounded up to a power of two, at least two), no request taken
`default_nettype none
module reference_broadcast_clock_sync import rbcs_pkg::*; #(
    parameter int ROWS  = ROWS_DEF,
    parameter int NODES = NODES_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    rbcs_in_if.sink               i_in,
    rbcs_out_if.source            o_out
);

    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int NW   = $clog2(NODES);
    localparam int AW   = RW + NW;
    localparam int CW   = $clog2(NODES + 1);
    localparam int UW   = $clog2(ROWS + 1);
    localparam int SUMW = TIME_W + UW;

    // row index by reciprocal multiplication
    localparam int MODS = ID_W + RW;
    localparam int MW   = ID_W + 2;
    localparam int QW   = ID_W + MW - MODS;
    localparam logic [MW-1:0] MOD_M = MW'((2**MODS + ROWS - 1) / ROWS);

    t_state r_state, n_state;

    logic [CFG_W-1:0]  r_me;
    logic [TIME_W-1:0] r_offset, n_offset;
    logic [ID_W-1:0]   r_row_ids [ROWS];

    logic [MODE_W-1:0] r_mode, n_mode;
    logic [ID_W-1:0]   r_id, n_id;
    logic [TIME_W-1:0] r_time, n_time;

    logic [AW-1:0]     r_clr, n_clr;
    logic [RW-1:0]     r_row, n_row;
    logic [NW-1:0]     r_i, n_i, r_j, n_j, r_wnode, n_wnode;
    logic              r_wok, n_wok;
    logic [TIME_W-1:0] r_mine, n_mine, r_cand, n_cand;
    logic [CW-1:0]     r_n, n_n, r_cl, n_cl, r_cle, n_cle, r_widest, n_widest;
    logic [UW-1:0]     r_used, n_used;
    logic [SUMW-1:0]   r_sum, n_sum;
    logic              r_adj, n_adj;
    logic [TIME_W-1:0] r_avg, n_avg;
    logic [QW-1:0]     r_modq, n_modq;
    logic              rid_we, oload;

    logic                     r_ovalid;
    logic                     r_o_adj;
    logic [TIME_W-1:0]        r_o_avg;
    logic [NOBS_W-1:0]        r_o_nodes;
    logic [USED_W-1:0]        r_o_used;
    logic [ID_W-1:0]          r_o_id;
    logic [TIME_W-1:0]        r_o_time;

    logic              mem_we;
    logic [AW-1:0]     mem_addr;
    logic [TIME_W-1:0] mem_wdata, mem_rdata;

    logic              div_start, div_done;
    logic [SUMW-1:0]   div_a, div_b, div_q, quot_s;

    logic              me_ok, lt, le, node_last_j, node_last_i;
    logic [CW-1:0]     cl_f, cle_f, k;
    logic [TIME_W-1:0] diff32;
    logic [ID_W+MW-1:0] mod_prod;
    logic [ID_W-1:0]   mod_rem;

    rbcs_store #(.AW(AW)) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    rbcs_div #(.W(SUMW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    assign me_ok       = r_me < CFG_W'(NODES);
    assign node_last_i = r_i == NW'(NODES - 1);
    assign node_last_j = r_j == NW'(NODES - 1);
    assign lt          = (mem_rdata != '0) && (mem_rdata < r_cand);
    assign le          = (mem_rdata != '0) && (mem_rdata <= r_cand);
    assign cl_f        = r_cl + CW'(lt);
    assign cle_f       = r_cle + CW'(le);
    assign k           = r_n >> 1;
    assign diff32      = r_cand - r_mine;
    assign quot_s      = r_sum[SUMW-1] ? (~div_q + 1'b1) : div_q;
    assign mod_prod    = {{MW{1'b0}}, r_id} * {{ID_W{1'b0}}, MOD_M};
    assign mod_rem     = r_id - ID_W'(r_modq) * ID_W'(ROWS);

    always_comb begin
        n_state  = r_state;
        n_offset = r_offset;
        n_mode   = r_mode;
        n_id     = r_id;
        n_time   = r_time;
        n_clr    = r_clr;
        n_row    = r_row;
        n_i      = r_i;
        n_j      = r_j;
        n_wnode  = r_wnode;
        n_wok    = r_wok;
        n_mine   = r_mine;
        n_cand   = r_cand;
        n_n      = r_n;
        n_cl     = r_cl;
        n_cle    = r_cle;
        n_widest = r_widest;
        n_used   = r_used;
        n_sum    = r_sum;
        n_adj    = r_adj;
        n_avg    = r_avg;
        n_modq   = r_modq;
        rid_we   = 1'b0;
        oload    = 1'b0;
        mem_we   = 1'b0;
        mem_addr = {r_row, r_j};
        mem_wdata = '0;
        div_start = 1'b0;
        div_a    = '0;
        div_b    = '0;
        unique case (r_state)
            S_CLR: begin
                mem_we   = 1'b1;
                mem_addr = r_clr;
                n_clr    = r_clr + 1'b1;
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in.valid) begin
                    n_mode   = i_in.mode;
                    n_id     = i_in.broadcast_id;
                    n_time   = i_in.time_value;
                    n_adj    = 1'b0;
                    n_avg    = '0;
                    n_widest = '0;
                    n_used   = '0;
                    n_sum    = '0;
                    n_row    = '0;
                    if (i_in.mode == MODE_REMOTE) begin
                        n_wnode = NW'(i_in.source_node);
                        n_wok   = CFG_W'(i_in.source_node) < CFG_W'(NODES);
                        n_state = S_MOD_START;
                    end else if (i_in.mode == MODE_LOCAL) begin
                        n_state = (i_in.start_of_set && me_ok) ? S_P_LOC : S_LOCAL;
                    end
                end
            end
            S_P_LOC: begin
                mem_addr = {r_row, r_me[NW-1:0]};
                n_state  = S_P_LOCD;
            end
            S_P_LOCD: begin
                n_mine = mem_rdata;
                n_j    = '0;
                n_i    = '0;
                n_n    = '0;
                n_state = (mem_rdata == '0) ? S_P_RCLR : S_P_CNT;
            end
            S_P_CNT: begin
                mem_addr = {r_row, r_i};
                n_state  = S_P_CNTD;
            end
            S_P_CNTD: begin
                n_n = r_n + CW'(mem_rdata != '0);
                if (node_last_i) begin
                    n_i     = '0;
                    n_state = S_P_CAND;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_P_CNT;
                end
            end
            S_P_CAND: begin
                mem_addr = {r_row, r_i};
                n_state  = S_P_CANDD;
            end
            S_P_CANDD: begin
                n_cand = mem_rdata;
                if (mem_rdata == '0) begin
                    n_i     = r_i + 1'b1;
                    n_state = S_P_CAND;
                end else begin
                    n_j     = '0;
                    n_cl    = '0;
                    n_cle   = '0;
                    n_state = S_P_CMP;
                end
            end
            S_P_CMP: begin
                mem_addr = {r_row, r_j};
                n_state  = S_P_CMPD;
            end
            S_P_CMPD: begin
                n_cl  = cl_f;
                n_cle = cle_f;
                if (node_last_j) begin
                    if ((cl_f <= k) && (k < cle_f)) begin
                        n_state = S_P_ACC;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = S_P_CAND;
                    end
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_P_CMP;
                end
            end
            S_P_ACC: begin
                n_sum  = r_sum + {{(SUMW - TIME_W){diff32[TIME_W-1]}}, diff32};
                n_used = r_used + 1'b1;
                if (r_n > r_widest) begin
                    n_widest = r_n;
                end
                n_j     = '0;
                n_state = S_P_RCLR;
            end
            S_P_RCLR: begin
                mem_we = 1'b1;
                if (node_last_j) begin
                    n_state = S_P_NEXT;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            S_P_NEXT: begin
                if (r_row == RW'(ROWS - 1)) begin
                    n_state = (r_used == '0) ? S_LOCAL : S_DIV_START;
                end else begin
                    n_row   = r_row + 1'b1;
                    n_state = S_P_LOC;
                end
            end
            S_DIV_START: begin
                div_start = 1'b1;
                div_a     = r_sum[SUMW-1] ? (~r_sum + 1'b1) : r_sum;
                div_b     = SUMW'(r_used);
                n_state   = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    n_avg    = quot_s[TIME_W-1:0];
                    n_offset = r_offset + quot_s[TIME_W-1:0];
                    n_adj    = 1'b1;
                    n_state  = S_LOCAL;
                end
            end
            S_LOCAL: begin
                n_time = r_time + r_offset;
                if (me_ok) begin
                    n_wnode = r_me[NW-1:0];
                    n_wok   = 1'b1;
                    n_state = S_MOD_START;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_MOD_START: begin
                n_modq  = mod_prod[ID_W+MW-1:MODS];
                n_state = S_MOD_WAIT;
            end
            S_MOD_WAIT: begin
                n_row   = mod_rem[RW-1:0];
                n_state = S_PREP;
            end
            S_PREP: begin
                n_j = '0;
                if (r_row_ids[r_row] != r_id) begin
                    rid_we  = 1'b1;
                    n_state = S_PCLR;
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_PCLR: begin
                mem_we = 1'b1;
                if (node_last_j) begin
                    n_state = S_WRITE;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            S_WRITE: begin
                mem_we    = r_wok;
                mem_addr  = {r_row, r_wnode};
                mem_wdata = r_time;
                n_state   = (r_mode == MODE_LOCAL) ? S_OUT : S_IDLE;
            end
            S_OUT: begin
                if (!r_ovalid || o_out.ready) begin
                    oload   = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_offset <= '0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_offset <= n_offset;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_id     <= n_id;
        r_time   <= n_time;
        r_row    <= n_row;
        r_i      <= n_i;
        r_j      <= n_j;
        r_wnode  <= n_wnode;
        r_wok    <= n_wok;
        r_mine   <= n_mine;
        r_cand   <= n_cand;
        r_n      <= n_n;
        r_cl     <= n_cl;
        r_cle    <= n_cle;
        r_widest <= n_widest;
        r_used   <= n_used;
        r_sum    <= n_sum;
        r_adj    <= n_adj;
        r_avg    <= n_avg;
        r_modq   <= n_modq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_me <= '0;
        end else if (i_cfg_we) begin
            r_me <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ROWS; r++) begin
                r_row_ids[r] <= '0;
            end
        end else if (rid_we) begin
            r_row_ids[r_row] <= r_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (oload) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (oload) begin
            r_o_adj   <= r_adj;
            r_o_avg   <= r_avg;
            r_o_nodes <= (32'(r_widest) > 32'd63) ? NOBS_W'(63) : NOBS_W'(r_widest);
            r_o_used  <= (32'(r_used) > 32'd15) ? USED_W'(15) : USED_W'(r_used);
            r_o_id    <= r_id;
            r_o_time  <= r_time;
        end
    end

    assign i_in.ready            = (r_state == S_IDLE);
    assign o_out.valid           = r_ovalid;
    assign o_out.adjusted        = r_o_adj;
    assign o_out.average_offset  = r_o_avg;
    assign o_out.nodes_observed  = r_o_nodes;
    assign o_out.references_used = r_o_used;
    assign o_out.reply_id        = r_o_id;
    assign o_out.reply_time      = r_o_time;

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !i_in.ready)
        else $error("request taken during store clear");

    a_div_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV_WAIT))
        else $error("divide finished outside a wait state");

    a_unadjusted_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.adjusted) |-> (o_out.references_used == '0))
        else $error("rows counted without adjustment");

    a_adjusted_nodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.adjusted) |-> (o_out.nodes_observed != '0))
        else $error("adjustment without observed nodes");

endmodule
`default_nettype wire
